FILE: rtl/core/tsrm_pkg.sv
`default_nettype none

package tsrm_pkg;

   localparam int TABLE_DEPTH_DEFAULT  = 256;
   localparam int SAMPLE_WIDTH_DEFAULT = 16;
   localparam int TABLE_DEPTH_MAX      = 4096;

   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int LEVEL_WIDTH     = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BIAS = 8'd1;

   localparam logic signed [CSR_DATA_WIDTH-1:0] GAIN_RESET = 32'sd65536;
   localparam logic signed [CSR_DATA_WIDTH-1:0] BIAS_RESET = 32'sd0;

   localparam logic [LEVEL_WIDTH-1:0] HALF_LEVEL = 16'h8000;
   localparam logic [LEVEL_WIDTH-1:0] FULL_LEVEL = 16'hFFFF;

   // tanh entries are Q0.16, one itself needs the seventeenth bit
   typedef logic [LEVEL_WIDTH:0] tanh_entry_type;
   typedef tanh_entry_type tanh_table_type [0:TABLE_DEPTH_MAX-1];

   // shift-subtract division, used only while the table is elaborated
   function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      int          i;
      rem = '0;
      quo = '0;
      for (i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // tanh(4*i/depth) from a Q32 series for exp(-1/depth), one entry per step
   function automatic tanh_table_type tanh_table_build(int depth);
      logic [127:0]   one;
      logic [127:0]   term;
      logic [127:0]   r;
      logic [127:0]   r8;
      logic [127:0]   e;
      logic [127:0]   den;
      logic [127:0]   num;
      logic [63:0]    step;
      tanh_table_type tbl;
      int             k;
      int             i;
      one  = 128'h1_0000_0000;
      term = one;
      r    = one;
      for (k = 1; k <= 6; k++) begin
         step = 64'(k) * 64'(depth);
         term = 128'(div_u64(term[63:0], step));
         if ((k % 2) == 1) begin
            r = r - term;
         end else begin
            r = r + term;
         end
      end
      r8 = one;
      for (k = 0; k < 8; k++) begin
         r8 = (r8 * r) >> 32;
      end
      e = one;
      for (i = 0; i < TABLE_DEPTH_MAX; i++) begin
         tbl[i] = '0;
         if (i < depth) begin
            den    = one + e;
            num    = ((one - e) << 16) + (den >> 1);
            tbl[i] = tanh_entry_type'(div_u64(num[63:0], den[63:0]));
            e      = (e * r8) >> 32;
         end
      end
      return tbl;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tsrm_if.sv
`default_nettype none

interface tsrm_req_if #(
   parameter int SAMPLE_WIDTH = tsrm_pkg::SAMPLE_WIDTH_DEFAULT
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface tsrm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [tsrm_pkg::LEVEL_WIDTH-1:0]   level;
   logic                               clipped;

   modport source (output valid, output level, output clipped, input ready);
   modport sink   (input valid, input level, input clipped, output ready);
endinterface

interface tsrm_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [tsrm_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [tsrm_pkg::CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tanh_soft_range_mapper.sv
`default_nettype none

// channel   dir  payload                          handshake
// req_port  in   sample (signed Q4.12)            valid/ready
// rsp_port  out  level (Q0.16), clipped           valid/ready
// csr_port  in   index (0 gain, 1 bias), data     valid/ready, ready always high
//
// One word per cycle while the output accepts them; each word passes through the six register
// stages (multiply, bias add, magnitude, index scale, table read, output).
// Every stage moves when the one after it is empty or moving, so bubbles close up
// and a stalled output leaves the earlier stages free to fill.
// Synchronous reset empties the pipeline and returns gain to 1.0 and bias to 0.

module tanh_soft_range_mapper #(
   parameter int TABLE_DEPTH  = tsrm_pkg::TABLE_DEPTH_DEFAULT,
   parameter int SAMPLE_WIDTH = tsrm_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   tsrm_req_if.sink    req_port,
   tsrm_rsp_if.source  rsp_port,
   tsrm_csr_if.sink    csr_port
);

   localparam int STAGES = 6;
   localparam int PW     = SAMPLE_WIDTH + tsrm_pkg::CSR_DATA_WIDTH;
   localparam int QW     = PW - 12;
   localparam int DW     = ((QW > tsrm_pkg::CSR_DATA_WIDTH) ? QW : tsrm_pkg::CSR_DATA_WIDTH) + 2;
   localparam int IW     = $clog2(TABLE_DEPTH);
   localparam int DBW    = $clog2(TABLE_DEPTH + 1);
   localparam int SW     = 16 + DBW;
   localparam int LW     = tsrm_pkg::LEVEL_WIDTH;

   localparam logic signed [DW-1:0] HALF_Q16 = DW'(32768);
   localparam logic [LW:0]          T_ONE    = (LW + 1)'(65536);
   localparam tsrm_pkg::tanh_table_type TANH_TABLE = tsrm_pkg::tanh_table_build(TABLE_DEPTH);

   // configuration
   logic signed [tsrm_pkg::CSR_DATA_WIDTH-1:0] gain_ff;
   logic signed [tsrm_pkg::CSR_DATA_WIDTH-1:0] bias_ff;

   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= tsrm_pkg::GAIN_RESET;
         bias_ff <= tsrm_pkg::BIAS_RESET;
      end else if (csr_port.valid) begin
         if (csr_port.index == tsrm_pkg::CSR_GAIN) begin
            gain_ff <= csr_port.data;
         end else if (csr_port.index == tsrm_pkg::CSR_BIAS) begin
            bias_ff <= csr_port.data;
         end
      end
   end

   // pipeline control
   logic [STAGES:1] stage_valid_ff;
   logic [STAGES:1] stage_en;

   always_comb begin
      stage_en[STAGES] = !stage_valid_ff[STAGES] || rsp_port.ready;
      for (int k = STAGES - 1; k >= 1; k--) begin
         stage_en[k] = !stage_valid_ff[k] || stage_en[k+1];
      end
   end

   assign req_port.ready = stage_en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         if (stage_en[1]) begin
            stage_valid_ff[1] <= req_port.valid;
         end
         for (int k = 2; k <= STAGES; k++) begin
            if (stage_en[k]) begin
               stage_valid_ff[k] <= stage_valid_ff[k-1];
            end
         end
      end
   end

   // side flags travel with their word
   logic [STAGES:1] zero_ff;
   logic [STAGES:3] neg_ff;
   logic [STAGES:3] clip_ff;

   // stage 1: sample times gain
   logic signed [SAMPLE_WIDTH-1:0] sample_s;
   logic signed [PW-1:0]           prod_in;
   logic signed [PW-1:0]           prod_ff;

   assign sample_s = req_port.sample;
   assign prod_in  = PW'(sample_s) * PW'(gain_ff);

   // stage 2: floor to Q16.16, add bias, remove one half
   logic signed [QW-1:0] q_s;
   logic signed [DW-1:0] diff_in;
   logic signed [DW-1:0] diff_ff;

   assign q_s     = $signed(prod_ff[PW-1:12]);
   assign diff_in = DW'(q_s) + DW'(bias_ff) - HALF_Q16;

   // stage 3: magnitude, saturation test on |n - 0.5| >= 1
   logic          neg_in;
   logic [DW-1:0] absd;
   logic          clip_in;
   logic [15:0]   frac_in;
   logic [15:0]   frac_ff;

   assign neg_in  = diff_ff[DW-1];
   assign absd    = neg_in ? DW'(-diff_ff) : DW'(diff_ff);
   assign clip_in = |absd[DW-1:16];
   assign frac_in = absd[15:0];

   // stage 4: table index, |x| * depth / 2^18 with |x| = 4 * |n - 0.5|
   logic [SW-1:0] scaled;
   logic [IW-1:0] idx_in;
   logic [IW-1:0] idx_ff;

   assign scaled = SW'(frac_ff) * SW'(TABLE_DEPTH);
   assign idx_in = scaled[16 +: IW];

   // stage 5: table read, one beyond the span
   logic [LW:0] t_in;
   logic [LW:0] t_ff;

   assign t_in = clip_ff[4] ? T_ONE : TANH_TABLE[idx_ff];

   // stage 6: fold around one half
   logic [LW-1:0] h;
   logic [LW:0]   up;
   logic [LW-1:0] level_in;
   logic          clipped_in;
   logic [LW-1:0] level_ff;
   logic          clipped_ff;

   assign h  = t_ff[LW:1];
   assign up = {1'b0, tsrm_pkg::HALF_LEVEL} + {1'b0, h};

   always_comb begin
      if (zero_ff[5]) begin
         level_in   = tsrm_pkg::HALF_LEVEL;
         clipped_in = 1'b0;
      end else if (neg_ff[5]) begin
         level_in   = tsrm_pkg::HALF_LEVEL - h;
         clipped_in = clip_ff[5];
      end else begin
         level_in   = up[LW] ? tsrm_pkg::FULL_LEVEL : up[LW-1:0];
         clipped_in = clip_ff[5];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         prod_ff    <= prod_in;
         zero_ff[1] <= (gain_ff == '0);
      end
      if (stage_en[2]) begin
         diff_ff    <= diff_in;
         zero_ff[2] <= zero_ff[1];
      end
      if (stage_en[3]) begin
         frac_ff    <= frac_in;
         neg_ff[3]  <= neg_in;
         clip_ff[3] <= clip_in;
         zero_ff[3] <= zero_ff[2];
      end
      if (stage_en[4]) begin
         idx_ff     <= idx_in;
         neg_ff[4]  <= neg_ff[3];
         clip_ff[4] <= clip_ff[3];
         zero_ff[4] <= zero_ff[3];
      end
      if (stage_en[5]) begin
         t_ff       <= t_in;
         neg_ff[5]  <= neg_ff[4];
         clip_ff[5] <= clip_ff[4];
         zero_ff[5] <= zero_ff[4];
      end
      if (stage_en[6]) begin
         level_ff   <= level_in;
         clipped_ff <= clipped_in;
         neg_ff[6]  <= neg_ff[5];
         clip_ff[6] <= clip_ff[5];
         zero_ff[6] <= zero_ff[5];
      end
   end

   assign rsp_port.valid   = stage_valid_ff[STAGES];
   assign rsp_port.level   = level_ff;
   assign rsp_port.clipped = clipped_ff;

   a_zero_gain_half: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && zero_ff[6] |-> rsp_port.level == tsrm_pkg::HALF_LEVEL
                                       && !rsp_port.clipped)
      else $error("zero gain word left the pipeline off one half");

   a_clip_at_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && rsp_port.clipped |-> rsp_port.level == tsrm_pkg::FULL_LEVEL
                                             || rsp_port.level == '0)
      else $error("saturated word not at a rail");

   a_clip_side_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && rsp_port.clipped |-> (neg_ff[6] == (rsp_port.level == '0))
                                             && clip_ff[6])
      else $error("saturated word on the wrong rail");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_port.ready |-> &stage_valid_ff)
      else $error("input held off with an empty stage");

endmodule

`default_nettype wire

FILE: bench/tsrm_level_checker.sv
`timescale 1ns / 1ps

module tsrm_level_checker (
   input  logic clock,
   input  logic reset,
   tsrm_req_if  req_mon,
   tsrm_rsp_if  rsp_mon,
   tsrm_csr_if  csr_mon,
   output int   mismatches,
   output int   expected_left,
   output int   levels_checked,
   output int   saturated_seen
);
   import tsrm_pkg::*;

   localparam int TABLE_DEPTH = TABLE_DEPTH_DEFAULT;

   typedef struct packed {
      logic [LEVEL_WIDTH-1:0] level;
      logic                   clipped;
   } level_word_type;

   logic [LEVEL_WIDTH:0]       curve [TABLE_DEPTH];
   logic signed [31:0]         gain_now;
   logic signed [31:0]         bias_now;
   level_word_type             pending_levels [$];
   level_word_type             want;
   int                         miss_total;
   int                         checked_total;
   int                         clip_total;

   // tanh(4*i/depth) in Q0.16, from a truncated Q32 series for exp(-1/depth)
   function automatic void build_curve();
      logic [127:0] unit_q32, term, r, r8, e, den, num;
      int           k;
      int           i;
      unit_q32 = 128'd1 << 32;
      term     = unit_q32;
      r        = unit_q32;
      for (k = 1; k <= 6; k++) begin
         term = term / 128'(k * TABLE_DEPTH);
         if ((k % 2) == 1) begin
            r = r - term;
         end else begin
            r = r + term;
         end
      end
      r8 = unit_q32;
      for (k = 0; k < 8; k++) begin
         r8 = (r8 * r) >> 32;
      end
      e = unit_q32;
      for (i = 0; i < TABLE_DEPTH; i++) begin
         den      = unit_q32 + e;
         num      = ((unit_q32 - e) << 16) + (den >> 1);
         curve[i] = (LEVEL_WIDTH + 1)'(num / den);
         e        = (e * r8) >> 32;
      end
   endfunction

   function automatic level_word_type predict_level(input logic signed [15:0] smp);
      level_word_type       res;
      logic signed [63:0]   prod;
      logic signed [63:0]   scaled;
      logic signed [63:0]   arg;
      logic [63:0]          mag;
      logic [63:0]          idx;
      logic [LEVEL_WIDTH:0] entry;
      logic [LEVEL_WIDTH:0] half_sum;
      if (gain_now == 0) begin
         res.level   = HALF_LEVEL;
         res.clipped = 1'b0;
      end else begin
         prod   = smp;
         prod   = prod * gain_now;
         // floor of the Q.28 product down to Q16.16, held wide so nothing wraps
         scaled = (prod >>> 12) + bias_now;
         arg    = (scaled - 64'sd32768) * 4;
         mag    = (arg < 0) ? -arg : arg;
         idx    = (mag * TABLE_DEPTH) >> 18;
         if (idx >= TABLE_DEPTH) begin
            entry       = 17'h1_0000;
            res.clipped = 1'b1;
         end else begin
            entry       = curve[idx];
            res.clipped = 1'b0;
         end
         if (arg >= 0) begin
            half_sum  = {1'b0, HALF_LEVEL} + {1'b0, entry[LEVEL_WIDTH:1]};
            res.level = (half_sum > {1'b0, FULL_LEVEL}) ? FULL_LEVEL
                                                        : half_sum[LEVEL_WIDTH-1:0];
         end else begin
            res.level = HALF_LEVEL - entry[LEVEL_WIDTH:1];
         end
      end
      return res;
   endfunction

   task automatic note_miss(input string what, input int exp_val, input int got_val);
      miss_total++;
      $display("%0t: %s expected %0d, got %0d", $time, what, exp_val, got_val);
   endtask

   initial begin
      build_curve();
      gain_now       = GAIN_RESET;
      bias_now       = BIAS_RESET;
      miss_total     = 0;
      checked_total  = 0;
      clip_total     = 0;
      mismatches     = 0;
      expected_left  = 0;
      levels_checked = 0;
      saturated_seen = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         gain_now = GAIN_RESET;
         bias_now = BIAS_RESET;
         pending_levels.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            pending_levels = {pending_levels, predict_level(req_mon.sample)};
         end
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_GAIN: gain_now = csr_mon.data;
               CSR_BIAS: bias_now = csr_mon.data;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_levels.size() == 0) begin
               note_miss("unrequested word, level", -1, rsp_mon.level);
            end else begin
               want = pending_levels.pop_front();
               checked_total++;
               if (rsp_mon.clipped === 1'b1) begin
                  clip_total++;
               end
               if (rsp_mon.level !== want.level) begin
                  note_miss("level", want.level, rsp_mon.level);
               end
               if (rsp_mon.clipped !== want.clipped) begin
                  note_miss("clipped", want.clipped, rsp_mon.clipped);
               end
            end
         end
      end
      mismatches     <= miss_total;
      expected_left  <= pending_levels.size();
      levels_checked <= checked_total;
      saturated_seen <= clip_total;
   end

endmodule

FILE: bench/tanh_soft_range_mapper_tb.sv
`timescale 1ns / 1ps

module tanh_soft_range_mapper_tb;
   import tsrm_pkg::*;

   localparam int RANDOM_SETTINGS   = 12;
   localparam int ITEMS_PER_SETTING = 140;
   localparam int HOLD_AT           = 300;
   localparam int LONG_HOLD         = 200;
   localparam int SETTLE            = 24;

   logic clock = 1'b0;
   logic reset;

   tsrm_req_if req_ch ();
   tsrm_rsp_if rsp_ch ();
   tsrm_csr_if csr_ch ();

   int mismatches;
   int expected_left;
   int levels_checked;
   int saturated_seen;
   int tx_idle_pct  = 7;
   int rx_idle_pct  = 75;
   int samples_sent = 0;
   int settings_used = 0;
   bit hold_done    = 1'b0;

   tanh_soft_range_mapper dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch),
      .csr_port (csr_ch)
   );

   tsrm_level_checker level_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_mon        (csr_ch),
      .mismatches     (mismatches),
      .expected_left  (expected_left),
      .levels_checked (levels_checked),
      .saturated_seen (saturated_seen)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #400_000;
      $display("*** FAILED ***");
      $finish;
   end

   // output side: random back-pressure plus one long stall once the stream is busy
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && samples_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   task automatic send_sample(input logic [15:0] value);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.sample <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      samples_sent++;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
   endtask

   task automatic csr_put(input logic [CSR_INDEX_WIDTH-1:0] idx,
                          input logic [CSR_DATA_WIDTH-1:0] word);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= word;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
   endtask

   // only call with the pipeline drained
   task automatic set_config(input logic [31:0] gain_word, input logic [31:0] bias_word);
      csr_put(CSR_GAIN, gain_word);
      // index past bias, must be dropped
      csr_put(CSR_BIAS + CSR_INDEX_WIDTH'($urandom_range(1, 254)), $urandom());
      csr_put(CSR_BIAS, bias_word);
      csr_ch.valid <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [15:0] next_sample_word();
      case ($urandom_range(0, 15))
         0:             next_sample_word = 16'h8000;
         1:             next_sample_word = 16'h7FFF;
         2, 3, 4, 5, 6: next_sample_word = 16'($urandom_range(0, 12287)) - 16'd6144;
         default:       next_sample_word = 16'($urandom());
      endcase
   endfunction

   initial begin
      logic [15:0] corners [7];
      logic [15:0] span_edges [7];
      logic [31:0] gain_word;
      logic [31:0] bias_word;
      int          kind;

      corners    = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0800,
                     16'hFFFF, 16'h5555, 16'hAAAA};
      span_edges = '{16'd4096, 16'd4095, 16'hF001, 16'hF000,
                     16'd0, 16'd16, 16'd15};

      reset         <= 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.sample <= '0;
      csr_ch.valid  <= 1'b0;
      csr_ch.index  <= '0;
      csr_ch.data   <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset settings: unit gain, no bias
      foreach (corners[i]) send_sample(corners[i]);
      drain();

      // zero gain pins the output at one half
      set_config(32'd0, $urandom());
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'h0800);
      drain();

      set_config(32'h7FFF_FFFF, 32'h8000_0000);
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'h0001);
      send_sample(16'hFFFF);
      drain();

      set_config(32'h8000_0000, 32'h7FFF_FFFF);
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'h0000);
      drain();

      // unit gain, bias one half: step across both ends of the table span
      set_config(GAIN_RESET, 32'd32768);
      foreach (span_edges[i]) send_sample(span_edges[i]);
      drain();

      for (int k = 0; k < RANDOM_SETTINGS; k++) begin
         if (k == RANDOM_SETTINGS / 3) begin
            tx_idle_pct = 75;
            rx_idle_pct = 7;
         end
         if (k == 2 * RANDOM_SETTINGS / 3) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         kind = (k < 8) ? k : $urandom_range(0, 7);
         case (kind)
            0, 1, 2, 3: begin
               // keep most samples inside the curve's live region
               gain_word = $urandom_range(1, 16384);
               if ($urandom_range(1)) gain_word = -gain_word;
               bias_word = 32'd32768 + $urandom_range(0, 131072) - 32'd65536;
            end
            4: begin
               gain_word = 32'd65536 + $urandom_range(0, 65536) - 32'd32768;
               if ($urandom_range(1)) gain_word = -gain_word;
               bias_word = 32'd32768 + $urandom_range(0, 131072) - 32'd65536;
            end
            5: begin
               gain_word = $urandom();
               bias_word = $urandom();
            end
            6: begin
               gain_word = 32'd0;
               bias_word = $urandom();
            end
            default: begin
               case ($urandom_range(0, 3))
                  0:       gain_word = 32'h7FFF_FFFF;
                  1:       gain_word = 32'h8000_0000;
                  2:       gain_word = 32'd1;
                  default: gain_word = 32'hFFFF_FFFF;
               endcase
               case ($urandom_range(0, 3))
                  0:       bias_word = 32'h7FFF_FFFF;
                  1:       bias_word = 32'h8000_0000;
                  2:       bias_word = 32'd32768;
                  default: bias_word = 32'd0;
               endcase
            end
         endcase
         set_config(gain_word, bias_word);
         for (int j = 0; j < ITEMS_PER_SETTING; j++) send_sample(next_sample_word());
         drain();
      end

      repeat (SETTLE) @(posedge clock);
      $display("Streamed %0d samples under %0d gain/bias settings, with a long output stall.",
               samples_sent, settings_used + 1);
      $display("Compared %0d levels, %0d of them past the table span.",
               levels_checked, saturated_seen);
      if (mismatches == 0 && expected_left == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
